/* hw/rtl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timeout queue package
// Shared types and constants for the cell chain and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  // Default number of timer slots.
  localparam int DEPTH_DEFAULT = 16;

  // Handles wrap back to one when the counter reaches this value.
  localparam logic [14:0] MAXSHORT = 15'h7FFF;

  // Largest reportable head wait.
  localparam logic [23:0] WAIT_MAX = 24'hFFFFFF;

  // Request opcodes.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_SERVICE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NOT_DUE   = 2'd3;

  // Request payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] period_ms;
    logic [14:0] target_handle;
    logic [23:0] elapsed_ms;
    logic        rearm;
  } stq_in_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] result_handle;
    logic        queue_nonempty;
    logic [14:0] head_handle;
    logic [23:0] head_wait_ms;
    logic        head_due;
    logic [8:0]  entry_count;
  } stq_out_t;

  // One queued timer as held in a cell.
  typedef struct packed {
    logic        valid;
    logic [14:0] handle;
    logic [23:0] period;
    logic [31:0] remaining;
  } stq_entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ADD,
    CELL_REMOVE,
    CELL_TICK,
    CELL_POP,
    CELL_POP_INS
  } stq_cell_op_t;

  // Control bundle broadcast along the chain.
  typedef struct packed {
    stq_cell_op_t op;
    logic [14:0]  handle;
    logic [23:0]  period;
    logic [14:0]  target;
    logic [23:0]  elapsed;
  } stq_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_timeout_queue_unit.sv */
// ----------------------------------------------------------------------------
// Sorted timeout queue unit
// Timer queue kept in order of remaining time in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage: requests enter on the in_ channel (valid/ready) and each produces
// exactly one result on the out_ channel. A request is one of add, remove,
// tick or service; every cell compares, shifts or decrements its own slot
// in the same cycle, so the whole queue updates on the edge of the transfer.
// The result is valid in the cycle after the request transfer, with the head
// fields read straight from the first cell.
// Throughput is one request per cycle while out_ready is high. The output
// register frees up in the same cycle its result is taken, so in_ready
// follows out_ready when a result is pending.
// When the receiver stalls, the result is held and no further request is
// taken, which keeps the cells and therefore the head fields stable.
// Reset empties the queue, sets the next handle to one and clears the
// result valid flag. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timeout_queue_unit #(
  parameter int DEPTH = stq_pkg::DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire stq_pkg::stq_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output stq_pkg::stq_out_t     out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  stq_pkg::stq_entry_t cells   [DEPTH];
  stq_pkg::stq_entry_t lefts   [DEPTH];
  stq_pkg::stq_entry_t rights  [DEPTH];
  logic                ins     [DEPTH];
  logic                hit     [DEPTH];
  logic                ins_left[DEPTH];
  logic                hit_left[DEPTH];

  stq_pkg::stq_ctrl_t  ctrl;
  stq_pkg::stq_entry_t head;
  logic                accept;
  logic                full;
  logic                due;
  logic                found;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [14:0]         next_handle_r, next_handle_nxt;
  logic [14:0]         handle_inc;
  logic                out_valid_r;
  logic [1:0]          status_r, status_nxt;
  logic [14:0]         rh_r, rh_nxt;

  // Cell chain: each cell sees both neighbors; the ends see empty slots.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i]    = '0;
      assign ins_left[i] = 1'b0;
      assign hit_left[i] = 1'b0;
    end else begin : g_mid
      assign lefts[i]    = cells[i-1];
      assign ins_left[i] = ins[i-1];
      assign hit_left[i] = hit[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = cells[i+1];
    end

    stq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .left_q  (lefts[i]),
      .right_q (rights[i]),
      .ins_in  (ins_left[i]),
      .hit_in  (hit_left[i]),
      .ins_out (ins[i]),
      .hit_out (hit[i]),
      .cell_q  (cells[i])
    );
  end

  assign head     = cells[0];
  assign full     = (count_r == CNT_W'(DEPTH));
  assign due      = head.valid && ($signed(head.remaining) <= 0);
  assign found    = hit[DEPTH-1];
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Handle counter skips zero by returning to one at the top value.
  assign handle_inc = next_handle_r + 15'd1;

  // Decode the request into a chain operation and the result fields.
  always_comb begin
    ctrl.op         = stq_pkg::CELL_HOLD;
    ctrl.handle     = next_handle_r;
    ctrl.period     = in_data.period_ms;
    ctrl.target     = in_data.target_handle;
    ctrl.elapsed    = in_data.elapsed_ms;
    status_nxt      = status_r;
    rh_nxt          = rh_r;
    count_nxt       = count_r;
    next_handle_nxt = next_handle_r;
    if (accept) begin
      status_nxt = stq_pkg::ST_OK;
      rh_nxt     = '0;
      unique case (in_data.opcode)
        stq_pkg::OP_ADD: begin
          if (full) begin
            status_nxt = stq_pkg::ST_FULL;
          end else begin
            ctrl.op         = stq_pkg::CELL_ADD;
            rh_nxt          = next_handle_r;
            count_nxt       = count_r + CNT_W'(1);
            next_handle_nxt = (handle_inc == stq_pkg::MAXSHORT) ? 15'd1 : handle_inc;
          end
        end
        stq_pkg::OP_REMOVE: begin
          ctrl.op = stq_pkg::CELL_REMOVE;
          if (found) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = stq_pkg::ST_NOT_FOUND;
          end
        end
        stq_pkg::OP_TICK: begin
          ctrl.op = stq_pkg::CELL_TICK;
        end
        stq_pkg::OP_SERVICE: begin
          ctrl.handle = head.handle;
          ctrl.period = head.period;
          if (!due) begin
            status_nxt = stq_pkg::ST_NOT_DUE;
          end else begin
            rh_nxt = head.handle;
            if (in_data.rearm) begin
              ctrl.op = stq_pkg::CELL_POP_INS;
            end else begin
              ctrl.op   = stq_pkg::CELL_POP;
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        default: begin
          ctrl.op = stq_pkg::CELL_HOLD;
        end
      endcase
    end
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      next_handle_r <= 15'd1;
      out_valid_r   <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      next_handle_r <= next_handle_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rh_r     <= rh_nxt;
  end

  // Result fields; head fields come from the first cell, which holds still
  // while a result waits.
  always_comb begin
    out_data.status         = status_r;
    out_data.result_handle  = rh_r;
    out_data.queue_nonempty = head.valid;
    out_data.head_handle    = head.valid ? head.handle : 15'd0;
    out_data.head_due       = due;
    out_data.entry_count    = 9'(count_r);
    if (!head.valid || $signed(head.remaining) <= 0) begin
      out_data.head_wait_ms = '0;
    end else if (head.remaining > {8'b0, stq_pkg::WAIT_MAX}) begin
      out_data.head_wait_ms = stq_pkg::WAIT_MAX;
    end else begin
      out_data.head_wait_ms = head.remaining[23:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hw/rtl/stq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted timeout queue cell
// Holds one timer slot and updates it from itself and its two neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stq_pkg::stq_ctrl_t ctrl,
  input  wire stq_pkg::stq_entry_t left_q,
  input  wire stq_pkg::stq_entry_t right_q,
  input  wire logic               ins_in,
  input  wire logic               hit_in,
  output logic                    ins_out,
  output logic                    hit_out,
  output stq_pkg::stq_entry_t     cell_q
);

  stq_pkg::stq_entry_t cell_r;
  stq_pkg::stq_entry_t cell_nxt;
  stq_pkg::stq_entry_t view;
  stq_pkg::stq_entry_t prior;
  stq_pkg::stq_entry_t fresh;
  logic                match;
  logic signed [32:0]  diff;

  // On a pop with reinsert the slot sees the queue already shifted left.
  always_comb begin
    view  = (ctrl.op == stq_pkg::CELL_POP_INS) ? right_q : cell_r;
    prior = (ctrl.op == stq_pkg::CELL_POP_INS) ? cell_r : left_q;
    fresh = '{valid: 1'b1, handle: ctrl.handle, period: ctrl.period,
              remaining: {8'b0, ctrl.period}};
    // The new entry goes before the first slot whose remaining time exceeds it.
    ins_out = !view.valid ||
              ($signed({9'b0, ctrl.period}) < $signed({view.remaining[31], view.remaining}));
    match   = cell_r.valid && (cell_r.handle == ctrl.target);
    hit_out = hit_in | match;
    diff    = $signed({cell_r.remaining[31], cell_r.remaining}) -
              $signed({9'b0, ctrl.elapsed});
  end

  // Next slot contents for each operation.
  always_comb begin
    cell_nxt = cell_r;
    unique case (ctrl.op)
      stq_pkg::CELL_HOLD: begin
        cell_nxt = cell_r;
      end
      stq_pkg::CELL_ADD, stq_pkg::CELL_POP_INS: begin
        if (ins_out) begin
          cell_nxt = ins_in ? prior : fresh;
        end else begin
          cell_nxt = view;
        end
      end
      stq_pkg::CELL_REMOVE: begin
        if (hit_out) begin
          cell_nxt = right_q;
        end
      end
      stq_pkg::CELL_TICK: begin
        // Subtraction only moves down, so a mismatch of the top bits is underflow.
        if (diff[32] != diff[31]) begin
          cell_nxt.remaining = 32'h8000_0000;
        end else begin
          cell_nxt.remaining = diff[31:0];
        end
      end
      stq_pkg::CELL_POP: begin
        cell_nxt = right_q;
      end
      default: begin
        cell_nxt = cell_r;
      end
    endcase
  end

  // Slot register; only the valid flag is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_q = cell_r;

endmodule

`default_nettype wire

/* sim/sorted_timeout_queue_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted timeout queue unit testbench
// Drives add, remove, tick and service requests into the timer queue with
// random idle gaps on both channels. A behavioral copy of the queue predicts
// every result, and each result transfer is checked field by field in order.
// ----------------------------------------------------------------------------

module sorted_timeout_queue_unit_tb;

  localparam int          DEPTH          = stq_pkg::DEPTH_DEFAULT;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int          REMAIN_FLOOR   = int'(32'h8000_0000);

  // Clock, reset and block ports.
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  stq_pkg::stq_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  stq_pkg::stq_out_t out_data;

  // Behavioral copy of the queue: slot 0 is the head.
  logic [14:0] slot_h [DEPTH];
  logic [23:0] slot_p [DEPTH];
  int          slot_r [DEPTH];
  int unsigned timer_count = 0;
  logic [14:0] handle_next = 15'd1;

  // Results still owed by the block, oldest first.
  stq_pkg::stq_out_t pending_reports [$];

  // Run control and bookkeeping.
  bit          gaps_on         = 1'b1;
  int unsigned ready_wait      = 0;
  int unsigned idle_cycles     = 0;
  int unsigned error_count     = 0;
  int unsigned reports_checked = 0;
  int unsigned op_count [4]    = '{0, 0, 0, 0};
  int unsigned full_hits       = 0;
  int unsigned saturations     = 0;

  sorted_timeout_queue_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Insert a timer after every entry whose remaining time is not above its period.
  function automatic void timer_place(input logic [14:0] h, input logic [23:0] p);
    int unsigned pos;
    pos = 0;
    while (pos < timer_count && !(longint'(p) < longint'(slot_r[pos]))) begin
      pos++;
    end
    for (int unsigned i = timer_count; i > pos; i--) begin
      slot_h[i] = slot_h[i - 1];
      slot_p[i] = slot_p[i - 1];
      slot_r[i] = slot_r[i - 1];
    end
    slot_h[pos] = h;
    slot_p[pos] = p;
    slot_r[pos] = int'(p);
    timer_count++;
  endfunction

  // Close the gap left by removing one slot.
  function automatic void timer_drop(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < timer_count; i++) begin
      slot_h[i] = slot_h[i + 1];
      slot_p[i] = slot_p[i + 1];
      slot_r[i] = slot_r[i + 1];
    end
    timer_count--;
  endfunction

  // Apply one request to the behavioral queue and return the result it owes.
  function automatic stq_pkg::stq_out_t predict_report(input stq_pkg::stq_in_t req);
    stq_pkg::stq_out_t rep;
    longint            diff;
    int unsigned       pos;
    logic [14:0]       h;
    logic [23:0]       p;
    rep = '0;
    rep.status = stq_pkg::ST_OK;
    case (req.opcode)
      stq_pkg::OP_ADD: begin
        if (timer_count >= DEPTH) begin
          rep.status = stq_pkg::ST_FULL;
          full_hits++;
        end else begin
          rep.result_handle = handle_next;
          timer_place(handle_next, req.period_ms);
          handle_next = handle_next + 15'd1;
          if (handle_next == stq_pkg::MAXSHORT) begin
            handle_next = 15'd1;
          end
        end
      end
      stq_pkg::OP_REMOVE: begin
        pos = 0;
        while (pos < timer_count && slot_h[pos] != req.target_handle) begin
          pos++;
        end
        if (pos < timer_count) begin
          timer_drop(pos);
        end else begin
          rep.status = stq_pkg::ST_NOT_FOUND;
        end
      end
      stq_pkg::OP_TICK: begin
        for (int unsigned i = 0; i < timer_count; i++) begin
          diff = longint'(slot_r[i]) - longint'(req.elapsed_ms);
          if (diff < longint'(REMAIN_FLOOR)) begin
            diff = longint'(REMAIN_FLOOR);
            saturations++;
          end
          slot_r[i] = int'(diff);
        end
      end
      default: begin
        if (timer_count == 0 || slot_r[0] > 0) begin
          rep.status = stq_pkg::ST_NOT_DUE;
        end else begin
          h = slot_h[0];
          p = slot_p[0];
          rep.result_handle = h;
          timer_drop(0);
          if (req.rearm) begin
            timer_place(h, p);
          end
        end
      end
    endcase
    // Head fields reflect the queue after the request.
    rep.queue_nonempty = (timer_count > 0);
    rep.entry_count    = 9'(timer_count);
    if (timer_count > 0) begin
      rep.head_handle = slot_h[0];
      rep.head_due    = (slot_r[0] <= 0);
      if (slot_r[0] <= 0) begin
        rep.head_wait_ms = '0;
      end else if (slot_r[0] > int'(stq_pkg::WAIT_MAX)) begin
        rep.head_wait_ms = stq_pkg::WAIT_MAX;
      end else begin
        rep.head_wait_ms = 24'(slot_r[0]);
      end
    end
    return rep;
  endfunction

  // Present one request, hold it until the transfer, then record its result.
  task automatic send_request(input stq_pkg::stq_in_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(predict_report(req));
    op_count[req.opcode]++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [23:0] period,
                         input logic [14:0] target, input logic [23:0] elapsed,
                         input logic rearm);
    stq_pkg::stq_in_t req;
    req.opcode        = op;
    req.period_ms     = period;
    req.target_handle = target;
    req.elapsed_ms    = elapsed;
    req.rearm         = rearm;
    send_request(req);
  endtask

  // Let every outstanding result arrive before the next test starts.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Random request; the mode biases the mix toward filling or draining.
  function automatic stq_pkg::stq_in_t random_request(input int unsigned mode);
    stq_pkg::stq_in_t req;
    int unsigned      roll;
    int unsigned      add_lim;
    int unsigned      rem_lim;
    int unsigned      tick_lim;
    req.period_ms     = 24'($urandom);
    req.target_handle = 15'($urandom);
    req.elapsed_ms    = 24'($urandom);
    req.rearm         = 1'($urandom);
    case (mode)
      0:       begin add_lim = 45; rem_lim = 60; tick_lim = 80; end
      1:       begin add_lim = 15; rem_lim = 40; tick_lim = 65; end
      default: begin add_lim = 30; rem_lim = 50; tick_lim = 75; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < add_lim) begin
      req.opcode = stq_pkg::OP_ADD;
    end else if (roll < rem_lim) begin
      req.opcode = stq_pkg::OP_REMOVE;
    end else if (roll < tick_lim) begin
      req.opcode = stq_pkg::OP_TICK;
    end else begin
      req.opcode = stq_pkg::OP_SERVICE;
    end
    // Mostly short periods so that ticks bring heads due.
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      req.period_ms = 24'($urandom_range(0, 200));
    end else if (roll < 85) begin
      req.period_ms = 24'($urandom_range(0, 5000));
    end
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      req.elapsed_ms = '0;
    end else if (roll < 55) begin
      req.elapsed_ms = 24'($urandom_range(0, 100));
    end else if (roll < 85) begin
      req.elapsed_ms = 24'($urandom_range(0, 2000));
    end
    // Removes mostly name a queued handle; the rest name zero, the next handle or a random one.
    roll = $urandom_range(0, 99);
    if (timer_count > 0 && roll < 70) begin
      req.target_handle = slot_h[$urandom_range(0, timer_count - 1)];
    end else if (roll < 90) begin
      req.target_handle = ($urandom_range(0, 1) != 0) ? 15'd0 : handle_next;
    end
    return req;
  endfunction

  // Empty-queue requests, ordering of equal periods, rearm and removal misses.
  task automatic test_edge_ops();
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_TICK, 24'd0, 15'd0, 24'hFFFFFF, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, 15'h7FFF, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'd0, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'hFFFFFF, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'd100, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'd100, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'd0, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b1);
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, 15'd3, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, 15'd3, 24'd0, 1'b0);
    send_op(stq_pkg::OP_TICK, 24'd0, 15'd0, 24'd50, 1'b0);
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b1);
    send_op(stq_pkg::OP_TICK, 24'd0, 15'd0, 24'd50, 1'b0);
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b1);
    wait_drain();
  endtask

  // Fill the queue, add into a full queue, then check no handle was used up.
  task automatic test_full_queue();
    while (timer_count < DEPTH) begin
      send_op(stq_pkg::OP_ADD, 24'($urandom_range(10, 100000)), 15'd0, 24'd0, 1'b0);
    end
    send_op(stq_pkg::OP_ADD, 24'd1, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'hFFFFFF, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, slot_h[DEPTH - 1], 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'd7, 15'd0, 24'd0, 1'b0);
    wait_drain();
  endtask

  // Batches of random requests with idling switched on or off per batch.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned mode;
    int unsigned batch;
    sent = 0;
    while (sent < count) begin
      mode    = $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 3) != 0);
      batch   = $urandom_range(20, 80);
      repeat (batch) begin
        send_request(random_request(mode));
        sent++;
      end
    end
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // Long run of large ticks drives every remaining time to the signed floor.
  task automatic test_tick_saturation();
    send_op(stq_pkg::OP_ADD, 24'hFFFFFF, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'd3, 15'd0, 24'd0, 1'b0);
    repeat (140) begin
      send_op(stq_pkg::OP_TICK, 24'($urandom), 15'($urandom),
              24'($urandom_range(24'hF00000, 24'hFFFFFF)), 1'($urandom));
    end
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b1);
    send_op(stq_pkg::OP_SERVICE, 24'd0, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_TICK, 24'd0, 15'd0, 24'd1, 1'b0);
    wait_drain();
  endtask

  // Empty the queue, churn short timers ahead of two long ones, then remove
  // the long ones by handle and miss on the same handles afterwards.
  task automatic test_handle_churn();
    logic [14:0] kept;
    logic [14:0] issued;
    gaps_on = 1'b0;
    while (timer_count > 0) begin
      send_op(stq_pkg::OP_REMOVE, 24'd0, slot_h[0], 24'd0, 1'b0);
    end
    // Two long timers stay queued while short ones come and go ahead of them.
    kept = handle_next;
    send_op(stq_pkg::OP_ADD, 24'hFFFFFF, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'hFFFFFF, 15'd0, 24'd0, 1'b0);
    repeat (10) begin
      issued = handle_next;
      send_op(stq_pkg::OP_ADD, 24'($urandom_range(0, 9)), 15'd0, 24'd0, 1'b0);
      send_op(stq_pkg::OP_REMOVE, 24'd0, issued, 24'd0, 1'b0);
    end
    // Each long timer is removed once; the repeats find nothing.
    send_op(stq_pkg::OP_ADD, 24'd5, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_ADD, 24'd5, 15'd0, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, kept, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, kept, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, kept + 15'd1, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, kept + 15'd1, 24'd0, 1'b0);
    send_op(stq_pkg::OP_REMOVE, 24'd0, kept, 24'd0, 1'b0);
    gaps_on = 1'b1;
    wait_drain();
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result side: random back-pressure with runs of steady acceptance.
  always @(posedge clk) begin
    if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      ready_wait <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest outstanding prediction.
  always @(posedge clk) begin
    stq_pkg::stq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("Result transfer with no request outstanding");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("result_handle", want.result_handle, out_data.result_handle);
        check_field("queue_nonempty", want.queue_nonempty, out_data.queue_nonempty);
        check_field("head_handle", want.head_handle, out_data.head_handle);
        check_field("head_wait_ms", want.head_wait_ms, out_data.head_wait_ms);
        check_field("head_due", want.head_due, out_data.head_due);
        check_field("entry_count", want.entry_count, out_data.entry_count);
        reports_checked++;
      end
    end
  end

  // Stop the run if neither channel makes progress for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_ops();
    test_full_queue();
    test_random_traffic(1260);
    test_tick_saturation();
    test_handle_churn();
    $display("Requests: %0d add, %0d remove, %0d tick, %0d service; %0d results checked",
             op_count[stq_pkg::OP_ADD], op_count[stq_pkg::OP_REMOVE],
             op_count[stq_pkg::OP_TICK], op_count[stq_pkg::OP_SERVICE], reports_checked);
    $display("Full-queue adds: %0d, saturated ticks: %0d", full_hits, saturations);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
